// ===== rtl/fvt_pkg.sv =====
package fvt_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int BOX_CORNERS = 8;
  localparam int Q_SHIFT     = 14;
  localparam int COORD_W     = 16;
  localparam int RADIUS_W    = 15;
  localparam int PROD_W      = 2 * COORD_W;
  localparam int DIST_W      = PROD_W + 3;
  localparam int CNT_W       = 4;
  localparam int CORNER_W    = 3;

  localparam int CFG_IW      = 3;
  localparam int CFG_DW      = 64;

  localparam int QDEPTH      = 4;
  localparam int QAW         = $clog2(QDEPTH);
  localparam int QCW         = $clog2(QDEPTH + 1);
  localparam int LVL_W       = $clog2(QDEPTH + 3);

  localparam logic [1:0] MODE_POINT  = 2'd0;
  localparam logic [1:0] MODE_SPHERE = 2'd1;
  localparam logic [1:0] MODE_BOX    = 2'd2;

  localparam logic [1:0] VERDICT_OUTSIDE   = 2'd0;
  localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
  localparam logic [1:0] VERDICT_INSIDE    = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] w;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nx;
  } plane_t;

  typedef struct packed {
    logic [1:0]             mode;
    logic [PLANE_COUNT-1:0] neg;
    logic [PLANE_COUNT-1:0] below;
    logic [PLANE_COUNT-1:0] touch;
  } cls_t;

endpackage

// ===== rtl/fvt_in_if.sv =====
interface fvt_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            mode;
  logic signed [fvt_pkg::COORD_W-1:0]    pos_x;
  logic signed [fvt_pkg::COORD_W-1:0]    pos_y;
  logic signed [fvt_pkg::COORD_W-1:0]    pos_z;
  logic [fvt_pkg::RADIUS_W-1:0]          radius;

  modport source(output valid, mode, pos_x, pos_y, pos_z, radius, input ready);
  modport sink(input valid, mode, pos_x, pos_y, pos_z, radius, output ready);
endinterface

// ===== rtl/fvt_out_if.sv =====
interface fvt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [1:0] tested_kind;

  modport source(output valid, verdict, tested_kind, input ready);
  modport sink(input valid, verdict, tested_kind, output ready);
endinterface

// ===== rtl/fvt_front.sv =====
module fvt_front (
  input  logic                          clk,
  input  logic                          rst_n,
  fvt_in_if.sink                        in_ch,
  input  logic                          cfg_we,
  input  logic [fvt_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [fvt_pkg::CFG_DW-1:0]    cfg_data,
  input  logic [fvt_pkg::QCW-1:0]       q_level,
  output logic                          push,
  output fvt_pkg::cls_t                 push_data
);

  fvt_pkg::plane_t                          plane_r [fvt_pkg::PLANE_COUNT];

  logic                                     s1_v_r;
  logic [1:0]                               s1_mode_r;
  logic [fvt_pkg::RADIUS_W-1:0]             s1_rad_r;
  logic signed [fvt_pkg::PROD_W-1:0]        prod_r [fvt_pkg::PLANE_COUNT][3];

  logic                                     s2_v_r;
  fvt_pkg::cls_t                            s2_r;
  fvt_pkg::cls_t                            s2_nxt;

  logic [fvt_pkg::LVL_W-1:0]                level;
  logic                                     accept;
  logic signed [fvt_pkg::DIST_W-1:0]        pdist [fvt_pkg::PLANE_COUNT];
  logic signed [fvt_pkg::DIST_W-1:0]        rq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fvt_pkg::PLANE_COUNT; i++) plane_r[i] <= '0;
    end else if (cfg_we) begin
      for (int i = 0; i < fvt_pkg::PLANE_COUNT; i++) begin
        if (cfg_index == fvt_pkg::CFG_IW'(i)) plane_r[i] <= cfg_data;
      end
    end
  end

  // hold off input unless every word in flight has a queue slot
  assign level = fvt_pkg::LVL_W'(q_level) + fvt_pkg::LVL_W'(s1_v_r)
               + fvt_pkg::LVL_W'(s2_v_r);
  assign in_ch.ready = (level < fvt_pkg::LVL_W'(fvt_pkg::QDEPTH));
  assign accept = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r <= in_ch.mode;
      s1_rad_r  <= in_ch.radius;
      for (int i = 0; i < fvt_pkg::PLANE_COUNT; i++) begin
        prod_r[i][0] <= plane_r[i].nx * in_ch.pos_x;
        prod_r[i][1] <= plane_r[i].ny * in_ch.pos_y;
        prod_r[i][2] <= plane_r[i].nz * in_ch.pos_z;
      end
    end
  end

  always_comb begin
    rq = fvt_pkg::DIST_W'({s1_rad_r, {fvt_pkg::Q_SHIFT{1'b0}}});
    s2_nxt = '0;
    s2_nxt.mode = s1_mode_r;
    for (int i = 0; i < fvt_pkg::PLANE_COUNT; i++) begin
      pdist[i] = fvt_pkg::DIST_W'(prod_r[i][0]) + fvt_pkg::DIST_W'(prod_r[i][1])
               + fvt_pkg::DIST_W'(prod_r[i][2])
               + (fvt_pkg::DIST_W'(plane_r[i].w) <<< fvt_pkg::Q_SHIFT);
      s2_nxt.neg[i]   = pdist[i] < 0;
      s2_nxt.below[i] = pdist[i] < -rq;
      s2_nxt.touch[i] = (pdist[i] >= -rq) && (pdist[i] <= rq);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) s2_r <= s2_nxt;
  end

  assign push      = s2_v_r;
  assign push_data = s2_r;

endmodule

// ===== rtl/fvt_queue.sv =====
module fvt_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  fvt_pkg::cls_t            push_data,
  input  logic                     pop,
  output logic                     nonempty,
  output fvt_pkg::cls_t            head,
  output logic [fvt_pkg::QCW-1:0]  level
);

  fvt_pkg::cls_t              mem [fvt_pkg::QDEPTH];
  logic [fvt_pkg::QAW-1:0]    wr_ptr_r;
  logic [fvt_pkg::QAW-1:0]    rd_ptr_r;
  logic [fvt_pkg::QCW-1:0]    count_r;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  assign nonempty = (count_r != '0);
  assign head     = mem[rd_ptr_r];
  assign level    = count_r;

endmodule

// ===== rtl/fvt_back.sv =====
module fvt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              nonempty,
  input  fvt_pkg::cls_t     head,
  output logic              pop,
  fvt_out_if.source         out_ch
);

  logic                             out_v_r;
  logic [1:0]                       verdict_r;
  logic [1:0]                       kind_r;
  logic [fvt_pkg::CORNER_W-1:0]     corner_r;
  logic [fvt_pkg::CNT_W-1:0]        cnt_r   [fvt_pkg::PLANE_COUNT];
  logic [fvt_pkg::CNT_W-1:0]        cnt_nxt [fvt_pkg::PLANE_COUNT];

  logic       last;
  logic       any_zero;
  logic       all_full;
  logic       emit;
  logic [1:0] verdict;

  assign pop  = nonempty && (!out_v_r || out_ch.ready);
  assign last = (corner_r == fvt_pkg::CORNER_W'(fvt_pkg::BOX_CORNERS - 1));

  always_comb begin
    any_zero = 1'b0;
    all_full = 1'b1;
    for (int i = 0; i < fvt_pkg::PLANE_COUNT; i++) begin
      cnt_nxt[i] = cnt_r[i] + fvt_pkg::CNT_W'(!head.neg[i]);
      if (cnt_nxt[i] == '0) any_zero = 1'b1;
      if (cnt_nxt[i] != fvt_pkg::CNT_W'(fvt_pkg::BOX_CORNERS)) all_full = 1'b0;
    end

    verdict = fvt_pkg::VERDICT_INSIDE;
    emit    = 1'b0;
    case (head.mode)
      fvt_pkg::MODE_POINT: begin
        emit = 1'b1;
        if (head.neg != '0) verdict = fvt_pkg::VERDICT_OUTSIDE;
      end
      fvt_pkg::MODE_SPHERE: begin
        emit = 1'b1;
        // lowest plane index decides
        for (int i = fvt_pkg::PLANE_COUNT - 1; i >= 0; i--) begin
          if (head.below[i])      verdict = fvt_pkg::VERDICT_OUTSIDE;
          else if (head.touch[i]) verdict = fvt_pkg::VERDICT_INTERSECT;
        end
      end
      fvt_pkg::MODE_BOX: begin
        emit = last;
        if (any_zero)      verdict = fvt_pkg::VERDICT_OUTSIDE;
        else if (all_full) verdict = fvt_pkg::VERDICT_INSIDE;
        else               verdict = fvt_pkg::VERDICT_INTERSECT;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r <= '0;
      for (int i = 0; i < fvt_pkg::PLANE_COUNT; i++) cnt_r[i] <= '0;
    end else if (pop && head.mode == fvt_pkg::MODE_BOX) begin
      corner_r <= corner_r + 1'b1;
      for (int i = 0; i < fvt_pkg::PLANE_COUNT; i++) begin
        cnt_r[i] <= last ? '0 : cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (pop && emit) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      verdict_r <= verdict;
      kind_r    <= head.mode;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.verdict     = verdict_r;
  assign out_ch.tested_kind = kind_r;

endmodule

// ===== rtl/frustum_visibility_test.sv =====
// Six-plane frustum classifier.
// in_ch carries one word per point, sphere or box corner (valid/ready);
// out_ch returns verdict and tested_kind (valid/ready). A box is eight
// corner words in a row and gets one result, on its eighth corner; mode 3
// words are dropped. Point and sphere words between corners leave the box
// count alone.
// cfg_we/cfg_index/cfg_data load plane registers 0..5 (left, right, top,
// bottom, near, far); other indices are ignored. Write only while idle.
// Each word passes the two pipe stages, the queue and an output register.
// Throughput: one word per cycle while out_ch.ready is high, set by the
// two-stage dot-product pipe (multiply, sum and compare) into a 4-entry queue.
// in_ch.ready drops only when the queue plus the words in the pipe already
// fill the queue, so a stalled receiver backs up through the queue to the
// input; nothing is lost.
// Reset (rst_n low, synchronous) clears the planes to zero, empties the
// pipe and queue, and clears the box corner and per-plane counts.
module frustum_visibility_test (
  input  logic                          clk,
  input  logic                          rst_n,
  fvt_in_if.sink                        in_ch,
  fvt_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [fvt_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [fvt_pkg::CFG_DW-1:0]    cfg_data
);

  logic                        push;
  fvt_pkg::cls_t               push_data;
  logic                        pop;
  logic                        nonempty;
  fvt_pkg::cls_t               head;
  logic [fvt_pkg::QCW-1:0]     q_level;

  fvt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_level   (q_level),
    .push      (push),
    .push_data (push_data)
  );

  fvt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .nonempty  (nonempty),
    .head      (head),
    .level     (q_level)
  );

  fvt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .nonempty (nonempty),
    .head     (head),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
